@@ rtl/encoder_position_speed_tracker_core_defines.svh @@
// Assertion macros used by the checker of this block.
`ifndef ENCODER_POSITION_SPEED_TRACKER_CORE_DEFINES_SVH
`define ENCODER_POSITION_SPEED_TRACKER_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define EPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define EPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

`endif

@@ rtl/eps_pkg.sv @@
`default_nettype none

package eps_pkg;

  localparam int STEP_W      = 19;
  localparam int ANGLE_W     = 32;
  localparam int COUNT_W     = 32;
  localparam int SUM_W       = 36;
  localparam int DIV_W       = 33;
  localparam int DIV_CNT_W   = 6;
  localparam int OUT_TDATA_W = 72;

  localparam logic [STEP_W-1:0] STEP_RESET = 19'd402;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_ZERO   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_TICK,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/encoder_position_speed_tracker_core.sv @@
// Init and angle update commands pass through the bit-serial divider (ST_DIV), a speed tick
// through ST_TICK, and a zero command goes straight to ST_RESULT, which waits while the output
// holds an unclaimed result. Throughput is one transaction at a time: the input is ready
// again in the cycle after the result register loads. Reset (rst, synchronous, active high)
// clears all counts, the sum and the ring, sets pulse_step to 402 and holds the input not
// ready.
`default_nettype none

module encoder_position_speed_tracker_core #(
  parameter int WINDOW = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration: pulse_step, written when cfg_we is high.
  input  wire logic                             cfg_we,
  input  wire logic [eps_pkg::STEP_W-1:0]       cfg_wdata,
  // Command input.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [eps_pkg::ANGLE_W-1:0]      s_axis_tdata,  // [31:0] angle
  input  wire logic [1:0]                       s_axis_tuser,  // [1:0] cmd
  // Result output.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [31:0] position, [67:32] speed_sum, [71:68] zero
  output logic [eps_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import eps_pkg::*;

  localparam int PTR_W = $clog2(WINDOW);

  // Architectural state of the encoder model.
  logic [STEP_W-1:0]  pulse_step;
  logic [COUNT_W-1:0] pulse_count;
  logic [COUNT_W-1:0] last_count;
  logic [COUNT_W-1:0] zero_offset;
  logic [ANGLE_W-1:0] reference_angle;
  logic [PTR_W-1:0]   ring_pointer;
  logic [SUM_W-1:0]   delta_total;

  // Sequencer state and the latched command.
  state_t             state;
  state_t             state_next;
  cmd_t               cmd_r;
  logic [ANGLE_W-1:0] angle_r;
  logic               neg_r;

  // Control strobes produced by the sequencer.
  logic in_acc;
  logic div_start;
  logic commit_div;
  logic commit_tick;
  logic out_load;

  cmd_t               cmd_in;
  logic [DIV_W-1:0]   diff;
  logic [DIV_W-1:0]   angle_ext;
  logic [DIV_W-1:0]   div_dividend;
  logic               div_neg;
  logic [STEP_W-1:0]  step_eff;

  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [STEP_W-1:0]  div_rem;
  logic [COUNT_W-1:0] q_signed;
  logic [ANGLE_W-1:0] rem_ext;

  logic [COUNT_W-1:0] ring_old;
  logic [COUNT_W-1:0] delta;
  logic [SUM_W-1:0]   total_next;

  assign cmd_in = cmd_t'(s_axis_tuser);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A step of zero is out of range and behaves as a step of one.
  assign step_eff = (pulse_step == '0) ? STEP_W'(1) : pulse_step;

  // Both init and update reduce to one unsigned division of a magnitude by the
  // step. Init divides the angle itself; update divides the distance from the
  // reference. In the update case the new reference is angle minus (or plus)
  // the remainder, which also covers the case where the distance is below one
  // step: the quotient is then zero and the reference stays where it was.
  assign angle_ext = {s_axis_tdata[ANGLE_W-1], s_axis_tdata};
  assign diff      = angle_ext - {reference_angle[ANGLE_W-1], reference_angle};

  always_comb begin
    if (cmd_in == CMD_INIT) begin
      div_neg = s_axis_tdata[ANGLE_W-1];
      div_dividend = div_neg ? DIV_W'(-angle_ext) : angle_ext;
    end else begin
      div_neg = diff[DIV_W-1];
      div_dividend = div_neg ? DIV_W'(-diff) : diff;
    end
  end

  eps_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (step_eff),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // The count wraps at 32 bits, so only the low quotient bits matter.
  assign q_signed = neg_r ? COUNT_W'(-div_quot[COUNT_W-1:0]) : div_quot[COUNT_W-1:0];
  assign rem_ext  = {{(ANGLE_W-STEP_W){1'b0}}, div_rem};

  // The ring is read at the pointer every cycle; the registered data is ready
  // in the cycle after a tick transaction is accepted.
  eps_ring #(
    .WINDOW (WINDOW),
    .PTR_W  (PTR_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .clear   (commit_div && cmd_r == CMD_INIT),
    .rd_addr (ring_pointer),
    .rd_data (ring_old),
    .wr_en   (commit_tick),
    .wr_addr (ring_pointer),
    .wr_data (delta)
  );

  assign delta      = pulse_count - last_count;
  assign total_next = delta_total + {{(SUM_W-COUNT_W){delta[COUNT_W-1]}}, delta}
                      - {{(SUM_W-COUNT_W){ring_old[COUNT_W-1]}}, ring_old};

  // Sequencer: next state and strobes. The input stays not ready during reset.
  always_comb begin
    state_next  = state;
    div_start   = 1'b0;
    commit_div  = 1'b0;
    commit_tick = 1'b0;
    out_load    = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = !rst;
        if (in_acc) begin
          unique case (cmd_in)
            CMD_INIT, CMD_UPDATE: begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
            CMD_TICK: state_next = ST_TICK;
            CMD_ZERO: state_next = ST_RESULT;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          commit_div = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_TICK: begin
        commit_tick = 1'b1;
        state_next  = ST_RESULT;
      end
      ST_RESULT: begin
        // Wait only if the previous result is still sitting unclaimed.
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_step <= STEP_RESET;
    end else if (cfg_we) begin
      pulse_step <= cfg_wdata;
    end
  end

  // Latch the command fields at acceptance.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= cmd_in;
      angle_r <= s_axis_tdata;
      neg_r   <= div_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count     <= '0;
      last_count      <= '0;
      zero_offset     <= '0;
      reference_angle <= '0;
      ring_pointer    <= '0;
      delta_total     <= '0;
    end else begin
      if (in_acc && cmd_in == CMD_ZERO) begin
        zero_offset <= pulse_count;
      end
      if (commit_div) begin
        if (cmd_r == CMD_INIT) begin
          pulse_count     <= q_signed;
          last_count      <= q_signed;
          reference_angle <= angle_r;
        end else begin
          pulse_count     <= pulse_count + q_signed;
          reference_angle <= neg_r ? angle_r + rem_ext : angle_r - rem_ext;
        end
      end
      if (commit_tick) begin
        delta_total  <= total_next;
        last_count   <= pulse_count;
        ring_pointer <= (ring_pointer == PTR_W'(WINDOW - 1)) ? '0 : ring_pointer + 1'b1;
      end
    end
  end

  // Output register: the next command can be taken while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{(OUT_TDATA_W-SUM_W-COUNT_W){1'b0}}, delta_total,
                       pulse_count - zero_offset};
    end
  end

endmodule

`default_nettype wire

@@ rtl/eps_divider.sv @@
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module eps_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [eps_pkg::DIV_W-1:0]   dividend,
  input  wire logic [eps_pkg::STEP_W-1:0]  divisor,
  output logic                             done,
  output logic [eps_pkg::DIV_W-1:0]        quotient,
  output logic [eps_pkg::STEP_W-1:0]       remainder
);
  import eps_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     quo;
  logic [STEP_W-1:0]    rem;
  logic [STEP_W-1:0]    dvs;
  logic [STEP_W:0]      trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? STEP_W'(trial - {1'b0, dvs}) : trial[STEP_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

@@ rtl/eps_ring.sv @@
`default_nettype none

// Delta ring storage with per-entry valid bits; an invalid entry reads as zero.
module eps_ring #(
  parameter int WINDOW = 16,
  parameter int PTR_W  = $clog2(WINDOW)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire logic [PTR_W-1:0]              rd_addr,
  output logic      [eps_pkg::COUNT_W-1:0]   rd_data,
  input  wire logic                          wr_en,
  input  wire logic [PTR_W-1:0]              wr_addr,
  input  wire logic [eps_pkg::COUNT_W-1:0]   wr_data
);
  import eps_pkg::*;

  logic [COUNT_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]  valid;
  logic [COUNT_W-1:0] rd_q;
  logic               rd_valid_q;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q       <= mem[rd_addr];
    rd_valid_q <= valid[rd_addr];
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/eps_checker.sv @@
`default_nettype none
`include "encoder_position_speed_tracker_core_defines.svh"

module eps_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [eps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import eps_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Transactions taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `EPS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_acc, !s_axis_tready)
  `EPS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `EPS_ASSERT_SAME(a_no_phantom, clk, rst, out_acc, pending != 2'd0)
  `EPS_ASSERT_SAME(a_no_overrun, clk, rst, 1'b1, pending != 2'd3)

endmodule

bind encoder_position_speed_tracker_core eps_checker u_eps_checker (.*);

`default_nettype wire

@@ tb/encoder_position_speed_tracker_core_tb.sv @@
`timescale 1ns / 1ps

module encoder_position_speed_tracker_core_tb;
  import eps_pkg::*;

  localparam int WINDOW = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SEG_COUNT = 8;
  localparam int SEG_ITEMS = 230;
  localparam int N_DIR = 25;
  // A zero entry in the step list below means "pick a random legal step".
  localparam logic [STEP_W-1:0] RANDOM_STEP = '0;
  localparam logic [STEP_W-1:0] MAX_STEP = 19'd411775;

  // One expected result: the two fields of m_axis_tdata.
  typedef struct packed {
    logic [COUNT_W-1:0] position;
    logic [SUM_W-1:0]   speed_sum;
  } enc_result_t;

  // One row of the directed stimulus. When check is set, the expected result
  // is taken from the row; otherwise the predictor supplies it.
  typedef struct packed {
    cmd_t               cmd;
    logic [ANGLE_W-1:0] angle;
    logic               check;
    logic [COUNT_W-1:0] position;
    logic [SUM_W-1:0]   speed_sum;
  } dir_row_t;

  // All rows run with the reset pulse step of 402.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // Straight after reset everything reads zero.
    '{CMD_ZERO,   32'd0,          1'b1, 32'd0,  36'd0},
    '{CMD_TICK,   32'd0,          1'b1, 32'd0,  36'd0},
    '{CMD_UPDATE, 32'd0,          1'b1, 32'd0,  36'd0},
    // One LSB short of a full pulse does not count.
    '{CMD_UPDATE, 32'd401,        1'b1, 32'd0,  36'd0},
    // Exactly one pulse up, then exactly one pulse back down.
    '{CMD_UPDATE, 32'd402,        1'b1, 32'd1,  36'd0},
    '{CMD_UPDATE, 32'd0,          1'b1, 32'd0,  36'd0},
    // Init to ten pulses; a tick ignores the angle it carries.
    '{CMD_INIT,   32'd4020,       1'b1, 32'd10, 36'd0},
    '{CMD_TICK,   32'hFFFF_FFFF,  1'b1, 32'd10, 36'd0},
    '{CMD_UPDATE, 32'd5226,       1'b1, 32'd13, 36'd0},
    '{CMD_TICK,   32'd0,          1'b1, 32'd13, 36'd3},
    '{CMD_ZERO,   32'd0,          1'b1, 32'd0,  36'd3},
    // Angle extremes, large deltas, and init at both ends of the range.
    '{CMD_UPDATE, 32'h7FFF_FFFF,  1'b0, 32'd0,  36'd0},
    '{CMD_TICK,   32'd0,          1'b0, 32'd0,  36'd0},
    '{CMD_UPDATE, 32'h8000_0000,  1'b0, 32'd0,  36'd0},
    '{CMD_TICK,   32'h8000_0000,  1'b0, 32'd0,  36'd0},
    '{CMD_INIT,   32'h8000_0000,  1'b0, 32'd0,  36'd0},
    '{CMD_TICK,   32'd0,          1'b0, 32'd0,  36'd0},
    '{CMD_INIT,   32'h7FFF_FFFF,  1'b0, 32'd0,  36'd0},
    // Negative angles truncate toward zero on init.
    '{CMD_INIT,   -32'sd403,      1'b0, 32'd0,  36'd0},
    '{CMD_UPDATE, -32'sd806,      1'b0, 32'd0,  36'd0},
    '{CMD_INIT,   -32'sd401,      1'b0, 32'd0,  36'd0},
    '{CMD_ZERO,   32'h5555_5555,  1'b0, 32'd0,  36'd0},
    '{CMD_TICK,   32'd0,          1'b0, 32'd0,  36'd0},
    '{CMD_UPDATE, 32'h5555_AAAA,  1'b0, 32'd0,  36'd0},
    '{CMD_TICK,   32'hAAAA_5555,  1'b0, 32'd0,  36'd0}
  };

  localparam logic [STEP_W-1:0] SEG_STEP [SEG_COUNT] = '{
    19'd1, MAX_STEP, 19'd3, STEP_RESET, RANDOM_STEP, MAX_STEP, 19'd1, RANDOM_STEP
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [STEP_W-1:0]      cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ANGLE_W-1:0]     s_axis_tdata = '0;   // [31:0] angle
  logic [1:0]             s_axis_tuser = '0;   // [1:0] cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [31:0] position, [67:32] speed_sum

  // Side channel that travels with each input transaction: a typed-in
  // expectation for directed rows that carry one.
  logic               row_check = 1'b0;
  logic [COUNT_W-1:0] row_position = '0;
  logic [SUM_W-1:0]   row_speed_sum = '0;

  // Idle percentages for the current phase, and the long receiver hold-off.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  // Predictor state: shaft tracking, position offset and the speed window.
  logic [STEP_W-1:0]  trk_step = STEP_RESET;
  logic [COUNT_W-1:0] trk_count = '0;
  logic [COUNT_W-1:0] trk_last = '0;
  logic [COUNT_W-1:0] trk_offset = '0;
  longint             trk_ref = 0;
  logic [COUNT_W-1:0] trk_ring [WINDOW];
  int                 trk_slot = 0;
  logic [SUM_W-1:0]   trk_sum = '0;

  enc_result_t expected_q [$];
  int          bad_results = 0;
  int          quiet_cycles = 0;

  encoder_position_speed_tracker_core #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Applies one command to the predicted encoder state and returns the
  // position and speed sum the block should report for it.
  function automatic enc_result_t track_encoder(cmd_t cmd, logic [ANGLE_W-1:0] angle);
    longint      ang;
    longint      stp;
    longint      diff;
    longint      n;
    longint      d_new;
    longint      d_old;
    logic [31:0] delta;
    enc_result_t r;
    ang = longint'($signed(angle));
    // A zero step is out of range and behaves as a step of one.
    stp = (trk_step == '0) ? 64'sd1 : longint'(trk_step);
    case (cmd)
      CMD_INIT: begin
        // Integer division in SystemVerilog truncates toward zero.
        n = ang / stp;
        trk_ref = ang;
        trk_count = n[31:0];
        trk_last = trk_count;
        for (int i = 0; i < WINDOW; i++) trk_ring[i] = '0;
        // The running sum and the ring slot deliberately survive init.
      end
      CMD_UPDATE: begin
        diff = ang - trk_ref;
        if (diff >= stp) begin
          n = diff / stp;
          trk_count = trk_count + n[31:0];
          trk_ref = trk_ref + n * stp;
        end else if (-diff >= stp) begin
          n = (-diff) / stp;
          trk_count = trk_count - n[31:0];
          trk_ref = trk_ref - n * stp;
        end
      end
      CMD_TICK: begin
        delta = trk_count - trk_last;
        d_new = longint'($signed(delta));
        d_old = longint'($signed(trk_ring[trk_slot]));
        trk_sum = trk_sum + 36'(d_new - d_old);
        trk_ring[trk_slot] = delta;
        trk_slot = (trk_slot + 1) % WINDOW;
        trk_last = trk_count;
      end
      default: begin
        trk_offset = trk_count;
      end
    endcase
    r.position = trk_count - trk_offset;
    r.speed_sum = trk_sum;
    return r;
  endfunction

  // Scoreboard: predicts on every accepted input transaction and checks every
  // accepted output transaction against the oldest pending expectation.
  always @(posedge clk) begin : scoreboard
    enc_result_t        want;
    logic [COUNT_W-1:0] got_pos;
    logic [SUM_W-1:0]   got_sum;
    logic [3:0]         got_pad;
    if (rst) begin
      trk_step = STEP_RESET;
      trk_count = '0;
      trk_last = '0;
      trk_offset = '0;
      trk_ref = 0;
      for (int i = 0; i < WINDOW; i++) trk_ring[i] = '0;
      trk_slot = 0;
      trk_sum = '0;
    end else begin
      if (cfg_we) begin
        trk_step = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = track_encoder(cmd_t'(s_axis_tuser), s_axis_tdata);
        if (row_check) begin
          want.position = row_position;
          want.speed_sum = row_speed_sum;
        end
        expected_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_pos = m_axis_tdata[31:0];
        got_sum = m_axis_tdata[67:32];
        got_pad = m_axis_tdata[71:68];
        if (expected_q.size() == 0) begin
          if (bad_results < 10) begin
            $display("%0t: result with nothing pending: position %0d speed_sum %0d",
                     $time, $signed(got_pos), $signed(got_sum));
          end
          bad_results++;
        end else begin
          want = expected_q.pop_front();
          if (got_pos !== want.position || got_sum !== want.speed_sum ||
              got_pad !== 4'd0) begin
            if (bad_results < 10) begin
              $display("%0t: mismatch: position exp %0d got %0d, speed_sum exp %0d got %0d, pad %h",
                       $time, $signed(want.position), $signed(got_pos),
                       $signed(want.speed_sum), $signed(got_sum), got_pad);
            end
            bad_results++;
          end
        end
      end
    end
  end

  // Receiver side: random back-pressure per phase, plus a long hold-off on
  // request so that the block fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: any stretch without a single transaction on either side that
  // lasts far beyond the longest legal stall ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one command and returns at the edge where it is accepted. An
  // optional random gap in front of it models an idle sender.
  task automatic send_command(input cmd_t cmd, input logic [ANGLE_W-1:0] angle,
                              input logic chk, input logic [COUNT_W-1:0] pos,
                              input logic [SUM_W-1:0] sum);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= angle;
    row_check <= chk;
    row_position <= pos;
    row_speed_sum <= sum;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops offering, waits for every pending result, then lets the block
  // settle for the given number of cycles.
  task automatic drain_results(input int settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [STEP_W-1:0]  cur_step;
    logic [STEP_W-1:0]  new_step;
    logic [ANGLE_W-1:0] stim_angle;
    logic [ANGLE_W-1:0] ang;
    cmd_t               cmd;
    longint             lim;
    longint             off;
    int                 r;
    cur_step = STEP_RESET;
    stim_angle = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset step, with no idling on either side.
    for (int k = 0; k < N_DIR; k++) begin
      send_command(DIR_ROWS[k].cmd, DIR_ROWS[k].angle, DIR_ROWS[k].check,
                   DIR_ROWS[k].position, DIR_ROWS[k].speed_sum);
    end

    // Random part: each segment changes the pulse step while idle and runs
    // under one of the idling phases.
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      new_step = SEG_STEP[seg];
      if (new_step == RANDOM_STEP) begin
        new_step = (seg == 4) ? STEP_W'($urandom_range(MAX_STEP, 1))
                              : STEP_W'($urandom_range(64, 2));
      end
      drain_results(40);
      cfg_we <= 1'b1;
      cfg_wdata <= new_step;
      @(posedge clk);
      cfg_we <= 1'b0;
      cur_step = new_step;

      case (seg % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 52; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 52; end
        default: begin tx_idle_pct = 10; rx_stall_pct <= 10; end
      endcase
      // Long receiver hold-off while the sender keeps offering commands.
      if (seg == 2 || seg == 6) begin
        holdoff_req <= holdoff_req + 1;
      end

      for (int i = 0; i < SEG_ITEMS; i++) begin
        // Halfway through, the sender pauses until the block has emptied.
        if (i == SEG_ITEMS / 2) begin
          drain_results(0);
        end
        r = $urandom_range(99);
        ang = $urandom();
        if (r < 6) begin
          cmd = CMD_INIT;
          if ($urandom_range(2) != 0) begin
            ang = stim_angle + 32'($urandom_range(4095)) - 32'd2048;
          end
          stim_angle = ang;
        end else if (r < 56) begin
          cmd = CMD_UPDATE;
          // Mostly small moves around the current shaft angle, so the count
          // walks up and down by a few pulses; the rest are arbitrary jumps.
          if ($urandom_range(99) >= 15) begin
            lim = longint'(cur_step) * $urandom_range(40) + $urandom_range(cur_step);
            off = longint'($urandom_range(32'(2 * lim))) - lim;
            ang = stim_angle + 32'(off);
          end
          stim_angle = ang;
        end else if (r < 86) begin
          cmd = CMD_TICK;
        end else begin
          cmd = CMD_ZERO;
        end
        send_command(cmd, ang, 1'b0, '0, '0);
      end
    end

    drain_results(50);
    if (bad_results == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
